/* rtl/core/scds_pkg.sv */
// Shared widths, constants and pipeline word types for the sine/cosine series block.
package scds_pkg;

  // Port field widths
  localparam int unsigned ANG_W     = 26;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned IN_DATA_W = 32;

  // Internal datapath widths, sized from the largest values over +/-360 degrees
  localparam int unsigned MAG_W   = 25;  // angle magnitude, Q16 degrees
  localparam int unsigned K_W     = 35;  // pi/180 in Q40
  localparam int unsigned X_W     = 33;  // angle in radians, Q30, up to 2*pi
  localparam int unsigned X2_W    = 36;  // square of the angle, Q30
  localparam int unsigned T_W     = 38;  // one series term, Q30
  localparam int unsigned ACC_W   = 40;  // signed partial sum, Q30
  localparam int unsigned NUM_W   = 43;  // rounded numerator ahead of the divide
  localparam int unsigned D_W     = 11;  // term divisor, up to 40*41
  localparam int unsigned RCP_W   = 42;  // divisor reciprocal width
  localparam int unsigned RCP_SH  = 42;  // reciprocal scale, 2^RCP_SH / d

  // Saturation bound of the input angle, +/-360 degrees in Q16
  localparam logic signed [ANG_W-1:0] ANG_LIMIT = 26'sd23592960;

  // Degrees to radians, rounded from pi in Q60
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [K_W-1:0] DEG_TO_RAD =
    K_W'((PI_Q60 + 64'd94371840) / 64'd188743680);

  // 1.0 in Q30 at accumulator width
  localparam logic signed [ACC_W-1:0] ONE_Q30 = 40'sd1073741824;

  // Word handed from one series cell to the next
  typedef struct packed {
    logic                    mode;  // 1 selects sine
    logic                    neg;   // input angle was negative
    logic [X2_W-1:0]         x2;
    logic [T_W-1:0]          term;
    logic signed [ACC_W-1:0] acc;
  } cell_data_t;

endpackage

/* rtl/core/sine_cosine_degrees_series.sv */
// Top level: degrees to radians, x^2, a row of series cells and the output skid buffer.
//
//   channel  | dir | handshake                   | word
//   ---------+-----+-----------------------------+--------------------------------
//   s_axis   | in  | s_axis_tvalid/s_axis_tready | angle in degrees Q16, mode bit
//   m_axis   | out | m_axis_tvalid/m_axis_tready | cosine or sine, Q30
//
// One word per cycle in and out while the output is not stalled; each cell has
// ten register stages (two split multipliers, divide correction, sum).
// Reset clears all valid bits; payload registers are left as they are.
// A stalled output holds one word in the output register and one in the skid
// register; the whole pipeline freezes only while the skid register is full.
module sine_cosine_degrees_series import scds_pkg::*; #(
  parameter int unsigned NUM_TERMS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [25:0] angle_deg, [31:26] zero
  input  logic                 s_axis_tuser,   // [0] mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [VAL_W-1:0]     m_axis_tdata    // [31:0] value
);

  typedef struct packed {
    logic mode;
    logic neg;
  } ang_side_t;

  typedef struct packed {
    logic           mode;
    logic           neg;
    logic [X_W-1:0] x;
  } rad_side_t;

  localparam int unsigned PK_W = MAG_W + K_W;
  localparam int unsigned PX_W = 2 * X_W;

  logic                    en;
  logic signed [ANG_W-1:0] ang_in, ang_sat, mag_full;
  logic                    s0_vld_q;
  logic [MAG_W-1:0]        s0_mag_q;
  ang_side_t               s0_side_q;

  logic                    mk_vld;
  logic [PK_W-1:0]         mk_prod;
  logic [$bits(ang_side_t)-1:0] mk_side;
  ang_side_t               mk_s;
  logic [PK_W:0]           x_sum;
  logic                    s1_vld_q;
  rad_side_t               s1_q;

  logic                    mx_vld;
  logic [PX_W-1:0]         mx_prod;
  logic [$bits(rad_side_t)-1:0] mx_side;
  rad_side_t               mx_s;
  logic [PX_W:0]           x2_sum;
  cell_data_t              s2_d;

  logic                    link_vld [NUM_TERMS+1];
  cell_data_t              link_dat [NUM_TERMS+1];

  cell_data_t              tail;
  logic signed [ACC_W-1:0] signed_sum, sat_sum;
  logic                    pipe_vld;
  logic [VAL_W-1:0]        pipe_val;
  logic                    out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic [VAL_W-1:0]        out_q, skid_q;
  logic                    out_take, load_out, load_skid, move_skid;

  // Pipeline advances unless the skid register holds a word
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  // Saturate the angle to +/-360 degrees and take its magnitude
  assign ang_in = $signed(s_axis_tdata[ANG_W-1:0]);
  always_comb begin
    priority if (ang_in > ANG_LIMIT) begin
      ang_sat = ANG_LIMIT;
    end else if (ang_in < -ANG_LIMIT) begin
      ang_sat = -ANG_LIMIT;
    end else begin
      ang_sat = ang_in;
    end
  end
  assign mag_full = ang_sat[ANG_W-1] ? -ang_sat : ang_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mag_q       <= mag_full[MAG_W-1:0];
      s0_side_q.mode <= s_axis_tuser;
      s0_side_q.neg  <= ang_sat[ANG_W-1];
    end
  end

  // Convert to radians
  scds_mul #(.WA(MAG_W), .WB(K_W), .WS($bits(ang_side_t))) u_mul_rad (
    .clk_i, .rst_ni,
    .en_i  (en),
    .vld_i (s0_vld_q),
    .a_i   (s0_mag_q),
    .b_i   (DEG_TO_RAD),
    .side_i(s0_side_q),
    .vld_o (mk_vld),
    .prod_o(mk_prod),
    .side_o(mk_side)
  );
  assign mk_s  = ang_side_t'(mk_side);
  assign x_sum = {1'b0, mk_prod} + (PK_W+1)'(1 << 25);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= mk_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.mode <= mk_s.mode;
      s1_q.neg  <= mk_s.neg;
      s1_q.x    <= x_sum[X_W+25:26];
    end
  end

  // Square the angle
  scds_mul #(.WA(X_W), .WB(X_W), .WS($bits(rad_side_t))) u_mul_x2 (
    .clk_i, .rst_ni,
    .en_i  (en),
    .vld_i (s1_vld_q),
    .a_i   (s1_q.x),
    .b_i   (s1_q.x),
    .side_i(s1_q),
    .vld_o (mx_vld),
    .prod_o(mx_prod),
    .side_o(mx_side)
  );
  assign mx_s   = rad_side_t'(mx_side);
  assign x2_sum = {1'b0, mx_prod} + (PX_W+1)'(1 << 29);

  // Seed the series: 1.0 for cosine, x for sine
  always_comb begin
    s2_d.mode = mx_s.mode;
    s2_d.neg  = mx_s.neg;
    s2_d.x2   = x2_sum[X2_W+29:30];
    s2_d.term = mx_s.mode ? T_W'(mx_s.x) : T_W'(ONE_Q30);
    s2_d.acc  = $signed({{(ACC_W-T_W){1'b0}}, s2_d.term});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld[0] <= 1'b0;
    end else if (en) begin
      link_vld[0] <= mx_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      link_dat[0] <= s2_d;
    end
  end

  // Row of series cells, one per term
  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_cell
    scds_cell #(.IDX(i + 1)) u_cell (
      .clk_i, .rst_ni,
      .en_i (en),
      .vld_i(link_vld[i]),
      .dat_i(link_dat[i]),
      .vld_o(link_vld[i+1]),
      .dat_o(link_dat[i+1])
    );
  end

  // Restore the sign for sine and clamp to +/-1.0
  assign tail       = link_dat[NUM_TERMS];
  assign signed_sum = (tail.mode && tail.neg) ? -tail.acc : tail.acc;
  always_comb begin
    priority if (signed_sum > ONE_Q30) begin
      sat_sum = ONE_Q30;
    end else if (signed_sum < -ONE_Q30) begin
      sat_sum = -ONE_Q30;
    end else begin
      sat_sum = signed_sum;
    end
  end
  assign pipe_vld = link_vld[NUM_TERMS];
  assign pipe_val = sat_sum[VAL_W-1:0];

  // Output register with one skid word behind it
  assign out_take  = out_vld_q && m_axis_tready;
  assign move_skid = skid_vld_q && out_take;
  assign load_out  = !skid_vld_q && pipe_vld && (!out_vld_q || out_take);
  assign load_skid = !skid_vld_q && pipe_vld && out_vld_q && !out_take;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (move_skid) begin
      skid_vld_d = 1'b0;
    end else if (load_out) begin
      out_vld_d = 1'b1;
    end else if (load_skid) begin
      skid_vld_d = 1'b1;
    end else if (out_take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= pipe_val;
    end
    if (load_skid) begin
      skid_q <= pipe_val;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

/* rtl/core/scds_mul.sv */
// Three-stage unsigned multiplier built from 32x32 partial products, with a sideband.
module scds_mul import scds_pkg::*; #(
  parameter int unsigned WA = 32,  // below 64
  parameter int unsigned WB = 32,  // below 64
  parameter int unsigned WS = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  input  logic [WS-1:0]    side_i,
  output logic             vld_o,
  output logic [WA+WB-1:0] prod_o,
  output logic [WS-1:0]    side_o
);

  logic [63:0]    a64, b64;
  logic [63:0]    ll_d, lh_d, hl_d, hh_d;
  logic [63:0]    ll_q, lh_q, hl_q, hh_q;
  logic [95:0]    s0_d, s1_d, s0_q, s1_q;
  logic [127:0]   p_full;
  logic [WA+WB-1:0] p_q;
  logic [2:0]     vld_q;
  logic [WS-1:0]  side_q [3];

  // Split both operands into 32-bit halves
  assign a64  = {{(64-WA){1'b0}}, a_i};
  assign b64  = {{(64-WB){1'b0}}, b_i};
  assign ll_d = {32'b0, a64[31:0]}  * {32'b0, b64[31:0]};
  assign lh_d = {32'b0, a64[31:0]}  * {32'b0, b64[63:32]};
  assign hl_d = {32'b0, a64[63:32]} * {32'b0, b64[31:0]};
  assign hh_d = {32'b0, a64[63:32]} * {32'b0, b64[63:32]};

  // Merge pairs, then the two halves
  assign s0_d   = {32'b0, ll_q} + {lh_q, 32'b0};
  assign s1_d   = {32'b0, hl_q} + {hh_q, 32'b0};
  assign p_full = {32'b0, s0_q} + {s1_q, 32'b0};

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Advance products and sideband
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q      <= ll_d;
      lh_q      <= lh_d;
      hl_q      <= hl_d;
      hh_q      <= hh_d;
      s0_q      <= s0_d;
      s1_q      <= s1_d;
      p_q       <= p_full[WA+WB-1:0];
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      side_q[2] <= side_q[1];
    end
  end

  assign vld_o  = vld_q[2];
  assign prod_o = p_q;
  assign side_o = side_q[2];

endmodule

/* rtl/core/scds_cell.sv */
// One series cell: next term = round(round(term * x^2) / d), then add or subtract it.
module scds_cell import scds_pkg::*; #(
  parameter int unsigned IDX = 1  // term number, 1 and up
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       vld_i,
  input  cell_data_t dat_i,
  output logic       vld_o,
  output cell_data_t dat_o
);

  localparam int unsigned D_COS = (2 * IDX - 1) * (2 * IDX);
  localparam int unsigned D_SIN = (2 * IDX) * (2 * IDX + 1);
  localparam logic [RCP_W-1:0] RECIP_COS = RCP_W'((64'd1 << RCP_SH) / D_COS);
  localparam logic [RCP_W-1:0] RECIP_SIN = RCP_W'((64'd1 << RCP_SH) / D_SIN);
  localparam logic [D_W-1:0] DIV_COS = D_W'(D_COS);
  localparam logic [D_W-1:0] DIV_SIN = D_W'(D_SIN);
  localparam logic [D_W-1:0] HALF_COS = D_W'(D_COS / 2);
  localparam logic [D_W-1:0] HALF_SIN = D_W'(D_SIN / 2);
  localparam bit SUB = (IDX % 2) == 1;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    cell_data_t       dat;
  } div_side_t;

  localparam int unsigned P1_W = T_W + X2_W;
  localparam int unsigned P2_W = NUM_W + RCP_W;

  logic              m1_vld;
  logic [P1_W-1:0]   m1_prod;
  logic [$bits(cell_data_t)-1:0] m1_side;
  cell_data_t        m1_dat;
  logic [P1_W:0]     rnd_sum;
  logic [D_W-1:0]    half_d;
  div_side_t         n_d, n_q;
  logic              n_vld_q;
  logic [RCP_W-1:0]  recip;

  logic              m2_vld;
  logic [P2_W-1:0]   m2_prod;
  logic [$bits(div_side_t)-1:0] m2_side;
  div_side_t         m2_s;
  logic [D_W-1:0]    div2;
  logic [NUM_W-1:0]  qe_d;
  logic [NUM_W+D_W-1:0] qd_full;

  logic              c_vld_q;
  logic [NUM_W-1:0]  qe_q, qd_q, num_c_q;
  cell_data_t        dat_c_q;
  logic [D_W-1:0]    div3;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  q_d;

  logic              q_vld_q;
  logic [T_W-1:0]    q_q;
  cell_data_t        dat_q_q;
  logic signed [ACC_W-1:0] q_ext;
  cell_data_t        out_d, out_q;
  logic              out_vld_q;

  // Multiply the term by x^2
  scds_mul #(.WA(T_W), .WB(X2_W), .WS($bits(cell_data_t))) u_mul_sq (
    .clk_i, .rst_ni, .en_i,
    .vld_i (vld_i),
    .a_i   (dat_i.term),
    .b_i   (dat_i.x2),
    .side_i(dat_i),
    .vld_o (m1_vld),
    .prod_o(m1_prod),
    .side_o(m1_side)
  );
  assign m1_dat = cell_data_t'(m1_side);

  // Round the product and add half the divisor in one constant add
  assign half_d  = m1_dat.mode ? HALF_SIN : HALF_COS;
  assign rnd_sum = {1'b0, m1_prod} + (P1_W+1)'(1 << 29)
                 + ({{(P1_W+1-D_W){1'b0}}, half_d} << 30);
  assign n_d.num = rnd_sum[NUM_W+29:30];
  assign n_d.dat = m1_dat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (en_i) begin
      n_vld_q <= m1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
    end
  end

  // Estimate the quotient by the scaled reciprocal, low by at most one
  assign recip = n_q.dat.mode ? RECIP_SIN : RECIP_COS;

  scds_mul #(.WA(NUM_W), .WB(RCP_W), .WS($bits(div_side_t))) u_mul_rcp (
    .clk_i, .rst_ni, .en_i,
    .vld_i (n_vld_q),
    .a_i   (n_q.num),
    .b_i   (recip),
    .side_i(n_q),
    .vld_o (m2_vld),
    .prod_o(m2_prod),
    .side_o(m2_side)
  );
  assign m2_s    = div_side_t'(m2_side);
  assign qe_d    = m2_prod[P2_W-1:RCP_SH];
  assign div2    = m2_s.dat.mode ? DIV_SIN : DIV_COS;
  assign qd_full = qe_d * div2;

  // Hold estimate and its back product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= m2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qe_q    <= qe_d;
      qd_q    <= qd_full[NUM_W-1:0];
      num_c_q <= m2_s.num;
      dat_c_q <= m2_s.dat;
    end
  end

  // Correct the estimate by one where the remainder reaches the divisor
  assign div3 = dat_c_q.mode ? DIV_SIN : DIV_COS;
  assign rem  = num_c_q - qd_q;
  assign q_d  = qe_q + NUM_W'(rem >= {{(NUM_W-D_W){1'b0}}, div3});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else if (en_i) begin
      q_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= q_d[T_W-1:0];
      dat_q_q <= dat_c_q;
    end
  end

  // Fold the new term into the sum with alternating sign
  assign q_ext = $signed({{(ACC_W-T_W){1'b0}}, q_q});

  always_comb begin
    out_d      = dat_q_q;
    out_d.term = q_q;
    out_d.acc  = SUB ? dat_q_q.acc - q_ext : dat_q_q.acc + q_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= q_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign vld_o = out_vld_q;
  assign dat_o = out_q;

endmodule

/* test/tb.sv */
// Testbench for the sine/cosine series block: bit-exact series predictor and stream checker.
`timescale 1ns / 100ps

module tb;
  import scds_pkg::*;

  localparam int unsigned TERMS       = 20;
  localparam int unsigned PIPE_DEPTH  = 10 * TERMS + 10;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RAND_WORDS  = 400;

  // Keeps the expected series values in order and compares each result word
  class sincos_scoreboard;
    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_RAD = (PI_Q60 + 64'd94371840) / 64'd188743680;
    localparam longint      DEG_MAX = 23592960;
    localparam longint      ONE     = 1073741824;

    logic [VAL_W-1:0] expected_values[$];
    int unsigned      errors;

    // Q30 product with half-up rounding, low 64 bits of the shifted result
    static function logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + (128'd1 << 29);
      return p[93:30];
    endfunction

    // Cosine or sine of the angle by the truncated series
    static function logic [VAL_W-1:0] series_value(logic [ANG_W-1:0] raw, logic sine);
      longint      ang;
      logic        neg;
      logic [63:0] mag;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] d;
      longint      acc;
      ang = longint'($signed(raw));
      if (ang > DEG_MAX) ang = DEG_MAX;
      if (ang < -DEG_MAX) ang = -DEG_MAX;
      neg  = ang < 0;
      mag  = neg ? -ang : ang;
      x    = (mag * DEG_RAD + (64'd1 << 25)) >> 26;
      x2   = mul_q30(x, x);
      term = sine ? x : 64'(ONE);
      acc  = longint'(term);
      for (int n = 1; n <= TERMS; n++) begin
        d    = sine ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
        term = mul_q30(term, x2);
        term = (term + d / 2) / d;
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (sine && neg) acc = -acc;
      if (acc > ONE) acc = ONE;
      if (acc < -ONE) acc = -ONE;
      return acc[VAL_W-1:0];
    endfunction

    function void note_angle(logic [ANG_W-1:0] raw, logic sine);
      expected_values.push_back(series_value(raw, sine));
    endfunction

    function void check_value(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (expected_values.size() == 0) begin
        $error("value: no word expected, got %0d", $signed(got));
        errors++;
        return;
      end
      want = expected_values.pop_front();
      if (got !== want) begin
        $error("value: expected %0d, got %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_values.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;  // [25:0] angle_deg, [31:26] zero
  logic                 s_axis_tuser  = 1'b0;  // [0] mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [VAL_W-1:0]     m_axis_tdata;  // [31:0] value

  int unsigned src_idle_pct = 32;
  int unsigned dst_idle_pct = 79;
  int unsigned idle_cycles  = 0;

  sincos_scoreboard sb = new();

  sine_cosine_degrees_series #(.NUM_TERMS(TERMS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  // Note accepted angles, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_angle(s_axis_tdata[ANG_W-1:0], s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_value(m_axis_tdata);
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one angle word, with a random gap ahead of it, and hold it until taken
  task automatic send_angle(input logic [ANG_W-1:0] ang, input logic mode);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - ANG_W){1'b0}}, ang};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Mostly in-range angles, some tiny ones and some past the saturation bound
  function automatic logic [ANG_W-1:0] random_angle();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return ANG_W'($signed($urandom_range(2 * 23592960)) - 23592960);
    if (pick < 8) return ANG_W'($signed($urandom_range(131072)) - 65536);
    return ANG_W'($urandom);
  endfunction

  initial begin
    logic [ANG_W-1:0] corner_angles[12];
    corner_angles = '{
      26'd0, 26'd23592960, -26'sd23592960, 26'h1FFFFFF, 26'h2000000,
      26'd5898240, -26'sd5898240, 26'd11796480, 26'd2949120, 26'd1, -26'sd1,
      26'd1966080
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner angles under both modes
    foreach (corner_angles[i]) begin
      send_angle(corner_angles[i], 1'b0);
      send_angle(corner_angles[i], 1'b1);
    end

    // Random angles: slow receiver first, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 79 : 0;
      dst_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 32 : 0;
      for (int i = 0; i < RAND_WORDS / 3 + 1; i++) begin
        send_angle(random_angle(), 1'($urandom_range(1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow for any stray word
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
